// ===== hw/rtl/tvs_pkg.sv =====
`default_nettype none

package tvs_pkg;

  localparam int TREE_W    = 8;
  localparam int DOC_W     = 31;
  localparam int VOTE_W    = 9;
  localparam int TOP_W     = 7;
  localparam int TCNT_W    = 9;
  localparam int KEY_W     = DOC_W + TREE_W;
  localparam int ENTRY_W   = DOC_W + VOTE_W;
  localparam int IN_W      = 40;
  localparam int HIST_SIZE = 257;
  localparam int HIST_AW   = 9;
  localparam int VOTE_CAP  = 256;
  localparam int CFG_AW    = 1;
  localparam int CFG_DW    = 9;

  localparam logic [CFG_AW-1:0] REG_TOP_COUNT  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_TREE_COUNT = 1'd1;

  localparam logic [TOP_W-1:0]  TOP_COUNT_RST  = 7'd16;
  localparam logic [TCNT_W-1:0] TREE_COUNT_RST = 9'd256;

  typedef enum logic [4:0] {
    S_LOAD,
    S_HCLR,
    S_PASS_CHK,
    S_RUN_INIT,
    S_MRD,
    S_MWR,
    S_VOTE_INIT,
    S_VRD,
    S_VPROC,
    S_FRD,
    S_FWR,
    S_WALK_INIT,
    S_WRD,
    S_WCHK,
    S_EMIT_INIT,
    S_ERD,
    S_ECHK,
    S_EOUT,
    S_EMPTY
  } tvs_state_t;

  typedef struct packed {
    logic load;
    logic hclr;
    logic pass_chk;
    logic run_init;
    logic pass_end;
    logic merge_wr;
    logic vote_init;
    logic vote_proc;
    logic fin_sel;
    logic fin_wr;
    logic walk_init;
    logic walk_step;
    logic walk_stop;
    logic emit_init;
    logic emit_skip;
    logic emit_out;
    logic empty_out;
  } tvs_cmd_t;

  typedef struct packed {
    logic in_last;
    logic hclr_last;
    logic sort_more;
    logic lo_lt_n;
    logic run_last;
    logic n_zero;
    logic grp_change;
    logic vote_last;
    logic all_read;
    logic walk_go;
    logic total_zero;
    logic match;
    logic scan_end;
    logic out_free;
    logic res_last;
  } tvs_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tvs_ram.sv =====
`default_nettype none

module tvs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tvs_ctrl.sv =====
`default_nettype none

module tvs_ctrl import tvs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tvs_stat_t stat,
  output tvs_cmd_t       cmd
);

  tvs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:      if (stat.in_last) state_next = S_HCLR;
      S_HCLR:      if (stat.hclr_last) state_next = S_PASS_CHK;
      S_PASS_CHK:  state_next = stat.sort_more ? S_RUN_INIT : S_VOTE_INIT;
      S_RUN_INIT:  state_next = stat.lo_lt_n ? S_MRD : S_PASS_CHK;
      S_MRD:       state_next = S_MWR;
      S_MWR:       state_next = stat.run_last ? S_RUN_INIT : S_MRD;
      S_VOTE_INIT: state_next = stat.n_zero ? S_WALK_INIT : S_VRD;
      S_VRD:       state_next = S_VPROC;
      S_VPROC: begin
        if (stat.grp_change || stat.vote_last) state_next = S_FRD;
        else state_next = S_VRD;
      end
      S_FRD:       state_next = S_FWR;
      S_FWR:       state_next = stat.all_read ? S_WALK_INIT : S_VRD;
      S_WALK_INIT: state_next = S_WRD;
      S_WRD:       state_next = S_WCHK;
      S_WCHK:      state_next = stat.walk_go ? S_WRD : S_EMIT_INIT;
      S_EMIT_INIT: state_next = stat.total_zero ? S_EMPTY : S_ERD;
      S_ERD:       state_next = S_ECHK;
      S_ECHK: begin
        if (stat.match) state_next = S_EOUT;
        else if (stat.scan_end) state_next = S_LOAD;
        else state_next = S_ERD;
      end
      S_EOUT: begin
        if (stat.out_free) begin
          if (stat.res_last || stat.scan_end) state_next = S_LOAD;
          else state_next = S_ERD;
        end
      end
      S_EMPTY:     if (stat.out_free) state_next = S_LOAD;
      default:     state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_LOAD:      cmd.load = 1'b1;
      S_HCLR:      cmd.hclr = 1'b1;
      S_PASS_CHK:  cmd.pass_chk = 1'b1;
      S_RUN_INIT: begin
        cmd.run_init = stat.lo_lt_n;
        cmd.pass_end = !stat.lo_lt_n;
      end
      S_MRD:       cmd = '0;
      S_MWR:       cmd.merge_wr = 1'b1;
      S_VOTE_INIT: cmd.vote_init = 1'b1;
      S_VRD:       cmd = '0;
      S_VPROC:     cmd.vote_proc = !stat.grp_change;
      S_FRD:       cmd.fin_sel = 1'b1;
      S_FWR: begin
        cmd.fin_sel = 1'b1;
        cmd.fin_wr  = 1'b1;
      end
      S_WALK_INIT: cmd.walk_init = 1'b1;
      S_WRD:       cmd = '0;
      S_WCHK: begin
        cmd.walk_step = stat.walk_go;
        cmd.walk_stop = !stat.walk_go;
      end
      S_EMIT_INIT: cmd.emit_init = 1'b1;
      S_ERD:       cmd = '0;
      S_ECHK:      cmd.emit_skip = !stat.match;
      S_EOUT:      cmd.emit_out = stat.out_free;
      S_EMPTY:     cmd.empty_out = stat.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tvs_dp.sv =====
`default_nettype none

module tvs_dp import tvs_pkg::*; #(
  parameter int MAX_PAIRS = 4096,
  parameter int MAX_TREES = 256,
  parameter int MAX_TOP   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tvs_cmd_t          cmd,
  output tvs_stat_t              stat,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              s_tvalid,
  input  wire logic [IN_W-1:0]   s_tdata,
  input  wire logic              s_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [ENTRY_W-1:0]     m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);

  localparam int AW = $clog2(MAX_PAIRS);
  localparam int CW = (AW + 2 > 10) ? AW + 2 : 10;

  // configuration
  logic [TOP_W-1:0]  top_count;
  logic [TCNT_W-1:0] tree_count;
  logic [TCNT_W-1:0] trees_ok, cap;
  logic [TOP_W-1:0]  limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count  <= TOP_COUNT_RST;
      tree_count <= TREE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TOP_COUNT:  top_count  <= cfg_wdata[TOP_W-1:0];
        REG_TREE_COUNT: tree_count <= cfg_wdata[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign trees_ok = (tree_count < TCNT_W'(MAX_TREES)) ? tree_count : TCNT_W'(MAX_TREES);
  assign cap      = (tree_count < TCNT_W'(VOTE_CAP)) ? tree_count : TCNT_W'(VOTE_CAP);
  assign limit    = (top_count < TOP_W'(MAX_TOP)) ? top_count : TOP_W'(MAX_TOP);

  // state
  logic [CW-1:0]      n, w, lo, mid, hi, i, j, k, nd, vote;
  logic               ovf, src_b, have, epass;
  logic [DOC_W-1:0]   prev_doc;
  logic [TREE_W-1:0]  prev_tree;
  logic [HIST_AW-1:0] haddr;
  logic [VOTE_W-1:0]  thr;
  logic [CW:0]        take;
  logic [TOP_W-1:0]   total, cnt;

  // input fields
  logic [TREE_W-1:0] in_tree;
  logic [DOC_W-1:0]  in_doc;
  logic              in_ok;
  assign in_tree = s_tdata[TREE_W-1:0];
  assign in_doc  = s_tdata[KEY_W-1:TREE_W];
  assign in_ok   = {1'b0, in_tree} < trees_ok;

  // pair memories, ping-pong between sort passes
  logic               we_a, we_b, load_wr, other_wr;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata, ra_a, ra_b, rb_a, rb_b;
  logic [ENTRY_W-1:0] src_x, src_y, dv_rd;

  tvs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PAIRS)) u_ram_a (
    .clk, .we(we_a), .waddr, .wdata,
    .raddr_a(i[AW-1:0]), .rdata_a(ra_a), .raddr_b(j[AW-1:0]), .rdata_b(ra_b)
  );
  tvs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PAIRS)) u_ram_b (
    .clk, .we(we_b), .waddr, .wdata,
    .raddr_a(i[AW-1:0]), .rdata_a(rb_a), .raddr_b(j[AW-1:0]), .rdata_b(rb_b)
  );

  assign src_x = src_b ? rb_a : ra_a;
  assign src_y = src_b ? rb_b : ra_b;
  assign dv_rd = src_b ? ra_a : rb_a;

  // merge choice
  logic [CW-1:0] mid_c, hi_c, w2;
  logic          take_i;
  assign w2     = w << 1;
  assign mid_c  = (lo + w < n) ? lo + w : n;
  assign hi_c   = (lo + w2 < n) ? lo + w2 : n;
  assign take_i = (i < mid) && ((j >= hi) || (src_x[KEY_W-1:0] <= src_y[KEY_W-1:0]));

  // vote scan
  logic [DOC_W-1:0]  v_doc;
  logic [TREE_W-1:0] v_tree;
  logic [VOTE_W-1:0] vsat;
  assign v_doc  = src_x[KEY_W-1:TREE_W];
  assign v_tree = src_x[TREE_W-1:0];
  assign vsat   = (vote > CW'(cap)) ? cap : vote[VOTE_W-1:0];

  assign load_wr  = cmd.load && s_tvalid && in_ok && (n < CW'(MAX_PAIRS));
  assign other_wr = cmd.merge_wr || cmd.fin_wr;
  assign we_a     = load_wr || (other_wr && src_b);
  assign we_b     = other_wr && !src_b;

  always_comb begin
    if (cmd.load) begin
      waddr = n[AW-1:0];
      wdata = ENTRY_W'({in_doc, in_tree});
    end else if (cmd.fin_wr) begin
      waddr = nd[AW-1:0];
      wdata = {vsat, prev_doc};
    end else begin
      waddr = k[AW-1:0];
      wdata = take_i ? src_x : src_y;
    end
  end

  // vote histogram
  logic              h_we;
  logic [HIST_AW-1:0] h_waddr, h_raddr;
  logic [CW-1:0]     h_wdata, h_rd;
  logic [CW:0]       take_sum;

  assign h_we    = cmd.hclr || cmd.fin_wr;
  assign h_waddr = cmd.hclr ? haddr : vsat;
  assign h_wdata = cmd.hclr ? '0 : h_rd + CW'(1);
  assign h_raddr = cmd.fin_sel ? vsat : thr;
  assign take_sum = take + {1'b0, h_rd};

  tvs_ram #(.WIDTH(CW), .DEPTH(HIST_SIZE)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr_a(h_raddr), .rdata_a(h_rd), .raddr_b(h_raddr), .rdata_b()
  );

  // result scan
  logic [VOTE_W-1:0] dv_vote;
  logic              batch_clr;
  assign dv_vote = dv_rd[ENTRY_W-1:DOC_W];
  assign batch_clr = (cmd.emit_out && stat.res_last) || cmd.empty_out ||
                     ((cmd.emit_out || cmd.emit_skip) && stat.scan_end);

  // status
  assign stat.in_last    = cmd.load && s_tvalid && s_tlast;
  assign stat.hclr_last  = haddr == HIST_AW'(HIST_SIZE - 1);
  assign stat.sort_more  = w < n;
  assign stat.lo_lt_n    = lo < n;
  assign stat.run_last   = (k + CW'(1)) == hi;
  assign stat.n_zero     = n == '0;
  assign stat.grp_change = have && (v_doc != prev_doc);
  assign stat.vote_last  = (i + CW'(1)) == n;
  assign stat.all_read   = i == n;
  assign stat.walk_go    = (thr > VOTE_W'(1)) && (take_sum <= (CW + 1)'(limit));
  assign stat.total_zero = total == '0;
  assign stat.match      = epass ? (dv_vote == thr) : (dv_vote > thr);
  assign stat.scan_end   = epass && ((i + CW'(1)) == nd);
  assign stat.out_free   = !m_tvalid || m_tready;
  assign stat.res_last   = (cnt + TOP_W'(1)) == total;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load && s_tvalid && in_ok) begin
        if (n < CW'(MAX_PAIRS)) n <= n + CW'(1);
        else ovf <= 1'b1;
      end
      if (batch_clr) begin
        n   <= '0;
        ovf <= 1'b0;
      end
      if (cmd.emit_out || cmd.empty_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      haddr <= '0;
      w     <= CW'(1);
      src_b <= 1'b0;
    end
    if (cmd.hclr) haddr <= haddr + HIST_AW'(1);
    if (cmd.pass_chk) lo <= '0;
    if (cmd.run_init) begin
      i   <= lo;
      j   <= mid_c;
      k   <= lo;
      mid <= mid_c;
      hi  <= hi_c;
    end
    if (cmd.pass_end) begin
      src_b <= !src_b;
      w     <= w2;
    end
    if (cmd.merge_wr) begin
      k <= k + CW'(1);
      if (take_i) i <= i + CW'(1);
      else j <= j + CW'(1);
      if (stat.run_last) lo <= lo + w2;
    end
    if (cmd.vote_init) begin
      i    <= '0;
      have <= 1'b0;
      nd   <= '0;
    end
    if (cmd.vote_proc) begin
      prev_doc  <= v_doc;
      prev_tree <= v_tree;
      have      <= 1'b1;
      i         <= i + CW'(1);
      if (!have) vote <= CW'(1);
      else if (v_tree != prev_tree) vote <= vote + CW'(1);
    end
    if (cmd.fin_wr) begin
      nd   <= nd + CW'(1);
      have <= 1'b0;
    end
    if (cmd.walk_init) begin
      thr  <= cap;
      take <= '0;
    end
    if (cmd.walk_step) begin
      take <= take_sum;
      thr  <= thr - VOTE_W'(1);
    end
    if (cmd.walk_stop) begin
      total <= (take_sum > (CW + 1)'(limit)) ? limit : take_sum[TOP_W-1:0];
    end
    if (cmd.emit_init) begin
      i     <= '0;
      epass <= 1'b0;
      cnt   <= '0;
    end
    if (cmd.emit_skip || cmd.emit_out) begin
      if ((i + CW'(1)) == nd) begin
        i     <= '0;
        epass <= 1'b1;
      end else begin
        i <= i + CW'(1);
      end
    end
    if (cmd.emit_out) begin
      cnt     <= cnt + TOP_W'(1);
      m_tdata <= dv_rd;
      m_tuser <= {ovf, 1'b0};
      m_tlast <= stat.res_last;
    end
    if (cmd.empty_out) begin
      m_tdata <= '0;
      m_tuser <= {ovf, 1'b1};
      m_tlast <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tree_vote_top_n_selector.sv =====
`default_nettype none

// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  one (tree, document) pair; tlast closes the batch
// m_*      out  m_tvalid/m_tready  one selected document with its vote; tlast ends batch
// cfg_*    in   cfg_we             register write: top_count, tree_count
//
// Pairs load at one per cycle; the closing pair stops input until results are out.
// Then the histogram is cleared, the pairs are merge sorted, the vote scan reads
// each pair and writes one entry per document, the threshold walk steps down the
// vote levels, and the result scan reads the documents in passes and outputs
// the results. Reset is synchronous; it restores the registers and empties
// the pair store. A stalled output holds the result register and the scan waits.

module tree_vote_top_n_selector import tvs_pkg::*; #(
  parameter int MAX_PAIRS = 4096,
  parameter int MAX_TREES = 256,
  parameter int MAX_TOP   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,   // tree_index[7:0], doc_id[38:8], zero pad
  input  wire logic              s_tlast,   // last_pair
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [ENTRY_W-1:0]     m_tdata,   // result_doc[30:0], result_vote[39:31]
  output logic [1:0]             m_tuser,   // empty_batch[0], pair_overflow[1]
  output logic                   m_tlast    // last_result
);

  tvs_cmd_t  cmd;
  tvs_stat_t stat;

  // sequencer: walks load, clear, sort, vote, threshold and output phases
  tvs_ctrl u_ctrl (
    .clk, .rst, .stat, .cmd
  );

  // pair store, histogram and result register
  tvs_dp #(
    .MAX_PAIRS(MAX_PAIRS),
    .MAX_TREES(MAX_TREES),
    .MAX_TOP  (MAX_TOP)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .s_tvalid, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  // take a pair transfer only while loading
  assign s_tready = cmd.load;

endmodule

`default_nettype wire
